/* hw/rtl/hct_pkg.sv */
// ----------------------------------------------------------------------------
// hct_pkg: handheld console timer shared types and constants
// Transaction payloads, request and register codes, and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package hct_pkg;

	// request types
	localparam logic [1:0] REQ_ADVANCE = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_WRITE   = 2'd2;

	// register select
	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_TIMA = 2'd1;
	localparam logic [1:0] REG_TMA  = 2'd2;
	localparam logic [1:0] REG_TAC  = 2'd3;

	// TAC period select
	localparam logic [1:0] PER_256 = 2'd0;
	localparam logic [1:0] PER_4   = 2'd1;
	localparam logic [1:0] PER_16  = 2'd2;
	localparam logic [1:0] PER_64  = 2'd3;

	localparam int TAC_EN_BIT = 2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] reg_sel;
		logic [7:0] write_data;
		logic [7:0] elapsed_cycles;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} rsp_t;

	typedef struct packed {
		logic accept;   // load a new transaction
		logic walk;     // run one counter step batch
		logic push;     // move result into the output register
	} hct_cmd_t;

	typedef struct packed {
		logic walk_done;
	} hct_sts_t;

endpackage

/* hw/rtl/hct_ctrl.sv */
// ----------------------------------------------------------------------------
// hct_ctrl: timer transaction controller
// Sequences accept, counter walk and result hand-off; owns the output valid.
// ----------------------------------------------------------------------------
module hct_ctrl
	import hct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output hct_cmd_t cmd,
	input  hct_sts_t sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.walk   = 1'b0;
		cmd.push   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_BUSY;
				end
			end
			ST_BUSY: begin
				cmd.walk = 1'b1;
				if (sts.walk_done && out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/hct_datapath.sv */
// ----------------------------------------------------------------------------
// hct_datapath: timer registers and counter step unit
// Holds DIV/TIMA/TMA/TAC and both prescalers. TIMA steps are walked one
// overflow per cycle: each cycle jumps straight to the next wrap or finishes.
// ----------------------------------------------------------------------------
module hct_datapath
	import hct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	output rsp_t     rsp,
	input  hct_cmd_t cmd,
	output hct_sts_t sts
);

	logic [7:0] div_q;
	logic [5:0] div_pre_q;
	logic [7:0] tima_q;
	logic [7:0] tma_q;
	logic [2:0] tac_q;
	logic [7:0] tima_pre_q;
	logic [6:0] steps_q;
	logic [7:0] rd_q;
	logic       irq_q;
	rsp_t       rsp_q;

	logic [8:0] div_acc;
	logic [8:0] tima_acc;
	logic [6:0] steps;
	logic [7:0] rem;
	logic [8:0] wrap_gap;
	logic [7:0] rd_mux;

	assign div_acc  = {3'b0, div_pre_q} + {1'b0, req.elapsed_cycles};
	assign tima_acc = {1'b0, tima_pre_q} + {1'b0, req.elapsed_cycles};
	// steps left until TIMA wraps from its current value
	assign wrap_gap = 9'd256 - {1'b0, tima_q};

	// periods are powers of two: quotient is a shift, remainder a mask
	always_comb begin
		case (tac_q[1:0])
			PER_256: begin
				steps = {6'b0, tima_acc[8]};
				rem   = tima_acc[7:0];
			end
			PER_4: begin
				steps = tima_acc[8:2];
				rem   = {6'b0, tima_acc[1:0]};
			end
			PER_16: begin
				steps = {2'b0, tima_acc[8:4]};
				rem   = {4'b0, tima_acc[3:0]};
			end
			default: begin
				steps = {4'b0, tima_acc[8:6]};
				rem   = {2'b0, tima_acc[5:0]};
			end
		endcase
	end

	always_comb begin
		unique case (req.reg_sel)
			REG_DIV:  rd_mux = div_q;
			REG_TIMA: rd_mux = tima_q;
			REG_TMA:  rd_mux = tma_q;
			REG_TAC:  rd_mux = {5'b0, tac_q};
			default:  rd_mux = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q      <= '0;
			div_pre_q  <= '0;
			tima_q     <= '0;
			tma_q      <= '0;
			tac_q      <= '0;
			tima_pre_q <= '0;
			steps_q    <= '0;
		end else if (cmd.accept) begin
			steps_q <= '0;
			unique case (req.req_type)
				REQ_ADVANCE: begin
					div_q     <= div_q + {5'b0, div_acc[8:6]};
					div_pre_q <= div_acc[5:0];
					if (tac_q[TAC_EN_BIT]) begin
						tima_pre_q <= rem;
						steps_q    <= steps;
					end
				end
				REQ_WRITE: begin
					unique case (req.reg_sel)
						REG_DIV: begin
							div_q     <= '0;
							div_pre_q <= '0;
						end
						REG_TIMA: tima_q <= req.write_data;
						REG_TMA:  tma_q  <= req.write_data;
						REG_TAC: begin
							if (!tac_q[TAC_EN_BIT] && req.write_data[TAC_EN_BIT])
								tima_pre_q <= '0;
							tac_q <= req.write_data[2:0];
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end else if (cmd.walk && steps_q != '0) begin
			if ({2'b0, steps_q} >= wrap_gap) begin
				tima_q  <= tma_q;
				steps_q <= steps_q - wrap_gap[6:0];
			end else begin
				tima_q  <= tima_q + {1'b0, steps_q};
				steps_q <= '0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q  <= (req.req_type == REQ_READ) ? rd_mux : 8'd0;
			irq_q <= 1'b0;
		end else if (cmd.walk && steps_q != '0 && {2'b0, steps_q} >= wrap_gap) begin
			irq_q <= 1'b1;
		end
		if (cmd.push) begin
			rsp_q.read_data <= rd_q;
			rsp_q.timer_irq <= irq_q;
		end
	end

	assign rsp           = rsp_q;
	assign sts.walk_done = (steps_q == '0);

endmodule

/* hw/rtl/handheld_console_timer.sv */
// ----------------------------------------------------------------------------
// handheld_console_timer: four-register console timer (DIV, TIMA, TMA, TAC)
// Top level joining the transaction controller and the timer datapath.
// ----------------------------------------------------------------------------
// One transaction at a time. Each accepted request goes to the busy state,
// where the step unit walks any TIMA steps (only an advance that steps TIMA
// has any), and leaves it once the walk is done and the output register is
// free. The step unit jumps from the current TIMA value to the next wrap
// each cycle, or finishes (worst case 127 overflows: an advance with
// elapsed_cycles at 255 on the fastest period with prescaler surplus left
// from a longer period, TIMA and TMA at 255). DIV and the prescalers update
// in the accept cycle. A finished result sits in an output register, so the
// next request is accepted the cycle after it is loaded, while it waits to be
// taken; no request is accepted while another is busy. A stalled output holds
// back the next finished result, and with it the acceptance of more requests.
module handheld_console_timer
	import hct_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	hct_cmd_t cmd;
	hct_sts_t sts;

	hct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	hct_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
